// File: rtl/core/txcw_pkg.sv
// ----------------------------------------------------------------------------
// txcw_pkg: shared types and constants for the text console writer
// Character codes, operation codes, register indexes and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package txcw_pkg;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] NUL_CHAR     = 8'h00;

    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_SET  = 2'd2;

    // register indexes on the config port
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [6:0] ROWS_RESET = 7'd25;
    localparam logic [7:0] COLS_RESET = 8'd80;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int TCOL_W  = 7;
    localparam int TROW_W  = 6;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 6;
    localparam int OIDX_W  = 13;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 8;

    typedef struct packed {
        logic clear_step;   // write one space during the reset sweep
        logic load_in;      // capture the accepted beat
        logic exec;         // evaluate the item, touch the store, move cursor
        logic scroll_step;  // one cell of the scroll copy/fill sweep
        logic finish;       // load the result register
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scroll_req;
        logic scroll_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: character screen writer with cursor
// Input beats on s_* carry one command (put char, read cell, set cursor);
// every beat yields exactly one result beat on m_* with the cursor after it.
// Screen size is set through the cfg_we/cfg_addr/cfg_wdata write port
// (index 0 rows, index 1 columns); the user must write it only while the
// unit is idle, which the unit itself does nothing to enforce. A beat is
// captured, evaluated in the exec state and its result loaded in the finish
// state; a new beat is taken on the edge the previous result is loaded. A put
// that moves past the bottom row adds a sweep: the store is copied up one row
// a cell per cycle over the single write port and the bottom row is blanked.
// Reset: the cursor goes to 0,0, size to 25x80, and the store is filled
// with spaces one cell per cycle, all MAX_ROWS*MAX_COLS cells (8192 by
// default), with s_tready low; config writes are taken during that time.
// Stall: results wait in the output register; while it is full and not
// taken the unit holds its finished item and keeps s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] func, [9:2] char_code, [16:10] target_col, [22:17] target_row
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] cursor_col, [12:7] cursor_row, [25:13] cursor_index,
    // [33:26] read_char, [39:34] zero
    output logic [39:0]      m_tdata,
    // [0] scrolled, [1] ignored
    output logic [1:0]       m_tuser
);

    txcw_pkg::cmd_t    cmd;
    txcw_pkg::status_t status;

    logic [txcw_pkg::OCOL_W-1:0] cursor_col;
    logic [txcw_pkg::OROW_W-1:0] cursor_row;
    logic [txcw_pkg::OIDX_W-1:0] cursor_index;
    logic [txcw_pkg::CHAR_W-1:0] read_char;
    logic                        scrolled;
    logic                        ignored;

    txcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    txcw_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_func          (s_tdata[1:0]),
        .in_char_code     (s_tdata[9:2]),
        .in_target_col    (s_tdata[16:10]),
        .in_target_row    (s_tdata[22:17]),
        .cmd              (cmd),
        .status           (status),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_cursor_col   (cursor_col),
        .out_cursor_row   (cursor_row),
        .out_cursor_index (cursor_index),
        .out_read_char    (read_char),
        .out_scrolled     (scrolled),
        .out_ignored      (ignored)
    );

    assign m_tdata = {6'b0, read_char, cursor_index, cursor_row, cursor_col};
    assign m_tuser = {ignored, scrolled};

endmodule

`default_nettype wire

// File: rtl/core/txcw_ctrl.sv
// ----------------------------------------------------------------------------
// txcw_ctrl: sequencing state machine
// Steps each item through evaluate, optional scroll sweep and result load;
// runs the store clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire txcw_pkg::status_t status,
    output txcw_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.scroll_req ? ST_SCROLL : ST_FINISH;
            end
            ST_SCROLL: begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // result goes out and the next beat may come in on the same edge
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/txcw_dpath.sv
// ----------------------------------------------------------------------------
// txcw_dpath: screen store, cursor and result datapath
// Holds the size registers, cursor, the character store with its sweep
// counter for clearing and scrolling, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_dpath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [txcw_pkg::COLS_W-1:0]   cfg_wdata,
    // input item
    input  wire logic [txcw_pkg::FUNC_W-1:0]   in_func,
    input  wire logic [txcw_pkg::CHAR_W-1:0]   in_char_code,
    input  wire logic [txcw_pkg::TCOL_W-1:0]   in_target_col,
    input  wire logic [txcw_pkg::TROW_W-1:0]   in_target_row,
    // control
    input  wire txcw_pkg::cmd_t                cmd,
    output txcw_pkg::status_t                  status,
    // result
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [txcw_pkg::OCOL_W-1:0]        out_cursor_col,
    output logic [txcw_pkg::OROW_W-1:0]        out_cursor_row,
    output logic [txcw_pkg::OIDX_W-1:0]        out_cursor_index,
    output logic [txcw_pkg::CHAR_W-1:0]        out_read_char,
    output logic                               out_scrolled,
    output logic                               out_ignored
);

    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int NCOL_W   = $clog2(MAX_COLS + 1);
    localparam int NROW_W   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int PW       = NCOL_W + ROW_W;

    // ---------------- config registers ----------------
    logic [txcw_pkg::ROWS_W-1:0] screen_rows_reg;
    logic [txcw_pkg::COLS_W-1:0] screen_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_rows_reg <= txcw_pkg::ROWS_RESET;
            screen_cols_reg <= txcw_pkg::COLS_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == txcw_pkg::CFG_ROWS) begin
                screen_rows_reg <= cfg_wdata[txcw_pkg::ROWS_W-1:0];
            end else begin
                screen_cols_reg <= cfg_wdata;
            end
        end
    end

    logic [NROW_W-1:0] rows_u;
    logic [NCOL_W-1:0] cols_u;
    logic              empty;

    always_comb begin
        if (int'(screen_rows_reg) > MAX_ROWS) begin
            rows_u = NROW_W'(MAX_ROWS);
        end else begin
            rows_u = NROW_W'(screen_rows_reg);
        end
        if (int'(screen_cols_reg) > MAX_COLS) begin
            cols_u = NCOL_W'(MAX_COLS);
        end else begin
            cols_u = NCOL_W'(screen_cols_reg);
        end
        empty = (rows_u == '0) || (cols_u == '0);
    end

    // ---------------- captured item ----------------
    logic [txcw_pkg::FUNC_W-1:0] func_reg;
    logic [txcw_pkg::CHAR_W-1:0] char_reg;
    logic [txcw_pkg::TCOL_W-1:0] tcol_reg;
    logic [txcw_pkg::TROW_W-1:0] trow_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= in_func;
            char_reg <= in_char_code;
            tcol_reg <= in_target_col;
            trow_reg <= in_target_row;
        end
    end

    // ---------------- item evaluation ----------------
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] last_col, sat_col, mul_col;
    logic [ROW_W-1:0] last_row, sat_row, mul_row;
    logic             col_wrap, row_ovf;
    logic             drop, scroll, store, rd_ok;
    logic [PW-1:0]    cell_prod;
    logic [ADDR_W-1:0] cell_addr;

    always_comb begin
        last_col = COL_W'(int'(cols_u) - 1);
        last_row = ROW_W'(int'(rows_u) - 1);
        sat_col  = (int'(cur_col_reg) >= int'(cols_u)) ? last_col : cur_col_reg;
        sat_row  = (int'(cur_row_reg) >= int'(rows_u)) ? last_row : cur_row_reg;
        col_wrap = (int'(sat_col) + 1) >= int'(cols_u);
        row_ovf  = (int'(sat_row) + 1) >= int'(rows_u);

        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        drop         = 1'b0;
        scroll       = 1'b0;
        store        = 1'b0;
        rd_ok        = 1'b0;
        mul_col      = sat_col;
        mul_row      = sat_row;

        unique case (func_reg)
            txcw_pkg::FUNC_PUT: begin
                if (empty || (char_reg == txcw_pkg::NUL_CHAR)) begin
                    drop = 1'b1;
                end else begin
                    cur_col_next = sat_col;
                    cur_row_next = sat_row;
                    store = (char_reg != txcw_pkg::NEWLINE_CHAR);
                    if ((char_reg == txcw_pkg::NEWLINE_CHAR) || col_wrap) begin
                        cur_col_next = '0;
                        // on overflow the cursor stays on the bottom row
                        if (row_ovf) begin
                            scroll = 1'b1;
                        end else begin
                            cur_row_next = sat_row + ROW_W'(1);
                        end
                    end else begin
                        cur_col_next = sat_col + COL_W'(1);
                    end
                end
            end
            txcw_pkg::FUNC_READ: begin
                if (empty || (int'(tcol_reg) >= int'(cols_u))
                          || (int'(trow_reg) >= int'(rows_u))) begin
                    drop = 1'b1;
                end else begin
                    rd_ok   = 1'b1;
                    mul_col = COL_W'(tcol_reg);
                    mul_row = ROW_W'(trow_reg);
                end
            end
            txcw_pkg::FUNC_SET: begin
                if (empty) begin
                    drop = 1'b1;
                end else begin
                    cur_col_next = (int'(tcol_reg) >= int'(cols_u)) ?
                                   last_col : COL_W'(tcol_reg);
                    cur_row_next = (int'(trow_reg) >= int'(rows_u)) ?
                                   last_row : ROW_W'(trow_reg);
                end
            end
            default: begin
                drop = 1'b1;
            end
        endcase

        cell_prod = PW'(cols_u) * PW'(mul_row);
        cell_addr = ADDR_W'(cell_prod + PW'(mul_col));
    end

    logic             scrolled_reg, ignored_reg, rd_ok_reg;
    logic [CNT_W-1:0] keep_reg, total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else if (cmd.exec) begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            scrolled_reg <= scroll;
            ignored_reg  <= drop;
            rd_ok_reg    <= rd_ok;
            keep_reg     <= CNT_W'(cols_u) * CNT_W'(rows_u - NROW_W'(1));
            total_reg    <= CNT_W'(cols_u) * CNT_W'(rows_u);
        end
    end

    // ---------------- sweep counter (clear / scroll) ----------------
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              copy;
    logic [ADDR_W-1:0] copy_src;

    assign copy     = CNT_W'(sweep_reg) < keep_reg;
    assign copy_src = ADDR_W'(CNT_W'(sweep_reg) + CNT_W'(cols_u));

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.clear_step) begin
            sweep_next = status.clear_last ? '0 : sweep_reg + ADDR_W'(1);
        end else if (cmd.exec) begin
            sweep_next = '0;
        end else if (cmd.scroll_step) begin
            sweep_next = sweep_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    // delayed write stage of the scroll sweep: the cell read in a cycle
    // lands one row up in the next
    logic              wr_valid_reg;
    logic              wr_copy_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= cmd.scroll_step;
        end
    end

    always_ff @(posedge aclk) begin
        wr_copy_reg <= copy;
        wr_addr_reg <= sweep_reg;
    end

    // ---------------- screen store ----------------
    logic [txcw_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [txcw_pkg::CHAR_W-1:0] rdata_reg;
    logic                        mem_we, mem_re;
    logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
    logic [txcw_pkg::CHAR_W-1:0] mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = txcw_pkg::SPACE_CHAR;
        priority if (cmd.clear_step) begin
            mem_we = 1'b1;
        end else if (cmd.exec && store) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr;
            mem_wdata = char_reg;
        end else if (wr_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_copy_reg ? rdata_reg : txcw_pkg::SPACE_CHAR;
        end else begin
            mem_we = 1'b0;
        end
        mem_re    = (cmd.exec && rd_ok) || (cmd.scroll_step && copy);
        mem_raddr = cmd.exec ? cell_addr : copy_src;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // ---------------- result register ----------------
    logic                        m_tvalid_reg;
    logic [PW-1:0]               idx_prod;
    logic [txcw_pkg::OCOL_W-1:0] o_col_reg;
    logic [txcw_pkg::OROW_W-1:0] o_row_reg;
    logic [txcw_pkg::OIDX_W-1:0] o_idx_reg;
    logic [txcw_pkg::CHAR_W-1:0] o_char_reg;
    logic                        o_scr_reg, o_ign_reg;

    assign idx_prod = PW'(cols_u) * PW'(cur_row_reg) + PW'(cur_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_col_reg  <= txcw_pkg::OCOL_W'(cur_col_reg);
            o_row_reg  <= txcw_pkg::OROW_W'(cur_row_reg);
            o_idx_reg  <= txcw_pkg::OIDX_W'(idx_prod);
            o_char_reg <= rd_ok_reg ? rdata_reg : txcw_pkg::NUL_CHAR;
            o_scr_reg  <= scrolled_reg;
            o_ign_reg  <= ignored_reg;
        end
    end

    assign status.clear_last  = (sweep_reg == ADDR_W'(DEPTH - 1));
    assign status.scroll_req  = scroll;
    assign status.scroll_last = (CNT_W'(sweep_reg) + CNT_W'(1)) == total_reg;
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid         = m_tvalid_reg;
    assign out_cursor_col   = o_col_reg;
    assign out_cursor_row   = o_row_reg;
    assign out_cursor_index = o_idx_reg;
    assign out_read_char    = o_char_reg;
    assign out_scrolled     = o_scr_reg;
    assign out_ignored      = o_ign_reg;

endmodule

`default_nettype wire
